### design/pae_pkg.sv
// ----------------------------------------------------------------------------
// pae_pkg: shared types and constants for the particle advection step
// Grid geometry, fixed-point constants, beat layouts and random-draw helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pae_pkg;

  localparam int GRID_X  = 16;
  localparam int GRID_Y  = 16;
  localparam int GRID_Z  = 16;
  localparam int CELLS   = GRID_X * GRID_Y * GRID_Z;
  localparam int CELL_AW = $clog2(CELLS);

  localparam logic [31:0] LFSR_SEED = 32'h2545_F491;
  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

  localparam logic [14:0] ONE_Q14     = 15'd16384;
  localparam logic [16:0] LIFE_DEC    = 17'd164;
  localparam logic [31:0] NORM_THRESH = 32'h0100_0000;
  localparam logic [15:0] TS_RESET    = 16'd1049;

  localparam int CFG_AW = 1;
  localparam int CFG_DW = 16;
  localparam logic [CFG_AW-1:0] REG_TIME_STEP = 1'b0;
  localparam logic [CFG_AW-1:0] REG_ENABLE    = 1'b1;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  typedef logic signed [15:0] q16_t;

  typedef struct packed {
    logic       func;
    q16_t       pos_x;
    q16_t       pos_y;
    q16_t       pos_z;
    q16_t       life_in;
    logic [3:0] cell_x;
    logic [3:0] cell_y;
    logic [3:0] cell_z;
    q16_t       vel_x;
    q16_t       vel_y;
    q16_t       vel_z;
  } in_beat_t;

  typedef struct packed {
    q16_t        next_x;
    q16_t        next_y;
    q16_t        next_z;
    logic [14:0] prev_x;
    logic [14:0] prev_y;
    logic [14:0] prev_z;
    q16_t        life_out;
    logic        respawned;
  } out_beat_t;

  typedef struct packed {
    logic        start;
    logic [31:0] sum;
    q16_t        vx;
    q16_t        vy;
    q16_t        vz;
  } norm_req_t;

  typedef struct packed {
    logic done;
    q16_t vx;
    q16_t vy;
    q16_t vz;
  } norm_rsp_t;

  // Sixteen Galois shifts; the whole thing is a fixed XOR network.
  function automatic logic [31:0] lfsr_step16(input logic [31:0] s);
    logic [31:0] t;
    t = s;
    for (int i = 0; i < 16; i++) begin
      t = (t >> 1) ^ (t[0] ? LFSR_TAPS : 32'h0);
    end
    return t;
  endfunction

  // Maps a 15-bit draw onto 0..16384.
  function automatic logic [14:0] coord_of(input logic [14:0] r);
    logic [29:0] t;
    t = {1'b0, r, 14'b0} + {15'b0, r};
    return t[29:15];
  endfunction

  function automatic logic [6:0] cell_of(input logic [14:0] p, input logic [6:0] size);
    logic [21:0] prod;
    logic [7:0]  c;
    prod = 22'(p) * 22'(size);
    c    = prod[21:14];
    return (c > 8'(size - 7'd1)) ? (size - 7'd1) : c[6:0];
  endfunction

endpackage

`default_nettype wire

### design/pae_if.sv
// ----------------------------------------------------------------------------
// pae_if: valid/ready channels for the particle advection step
// One interface for the item channel and one for the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface pae_in_if import pae_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pae_out_if import pae_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/particle_advect_step.sv
// ----------------------------------------------------------------------------
// particle_advect_step: Euler advection of one particle through a velocity grid
// Holds the velocity grid memory, respawn generator and move sequencer.
// ----------------------------------------------------------------------------
//   channel   dir  content
//   in_ch     in   load of one velocity cell, or one particle to advance
//   out_ch    out  advanced particle (none for loads or while disabled)
//   cfg_*     in   register writes: time step, enable
//
// A load beat writes the grid memory when it is taken. An advance beat runs the
// sequencer; when the velocity is longer than one, the shared square-root and
// divide unit first takes the root and then divides each component by it.
// Reset is synchronous; the grid memory is not cleared and must be loaded.
// A finished result waits in the output register; a new beat is taken
// meanwhile, and the sequencer holds only if the next result finds it full.
`default_nettype none

module particle_advect_step import pae_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data,
  pae_in_if.sink                 in_ch,
  pae_out_if.source              out_ch
);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_SQ, S_CHK, S_NORM, S_MOVE, S_DONE} state_t;

  state_t       state_r;
  logic [15:0]  ts_r;
  logic         en_r;
  logic [31:0]  lfsr_r;
  logic [14:0]  p_r [3];
  q16_t         life_r;
  logic         resp_r;
  logic [CELL_AW-1:0] addr_r;
  logic [47:0]  rd_q;
  q16_t         v_r [3];
  logic [31:0]  s_r;
  logic [1:0]   k_r;
  q16_t         nx_r [3];
  logic         out_valid_r;
  out_beat_t    out_r;

  logic [47:0]  grid_mem [CELLS];

  norm_req_t    nreq;
  norm_rsp_t    nrsp;

  logic         acc;
  logic         load_ok;
  logic [CELL_AW-1:0] load_addr;
  logic         resp;
  logic [31:0]  s1, s2, s3, s4;
  logic [14:0]  psel [3];
  q16_t         pin [3];
  logic [16:0]  life_dec;
  q16_t         life_nxt;
  logic [6:0]   tx, ty, tz;
  logic [CELL_AW-1:0] adv_addr;
  q16_t         rdv [3];
  logic signed [31:0] sq;
  q16_t         vk;
  logic [15:0]  mag;
  logic [31:0]  prod;
  logic [32:0]  rnd;
  logic signed [19:0] d;
  logic signed [20:0] sum;
  q16_t         nxt;
  logic         out_free;

  assign acc      = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    pin[0] = in_ch.data.pos_x;
    pin[1] = in_ch.data.pos_y;
    pin[2] = in_ch.data.pos_z;
    load_ok = (7'(in_ch.data.cell_x) < 7'(GRID_X)) && (7'(in_ch.data.cell_y) < 7'(GRID_Y))
           && (7'(in_ch.data.cell_z) < 7'(GRID_Z));
    load_addr = CELL_AW'((int'(in_ch.data.cell_z) * GRID_Y + int'(in_ch.data.cell_y))
                         * GRID_X + int'(in_ch.data.cell_x));
    resp = in_ch.data.life_in[15];
    for (int i = 0; i < 3; i++) begin
      if (pin[i][15] || (pin[i] > 16'sd16384)) resp = 1'b1;
    end
    s1 = lfsr_step16(lfsr_r);
    s2 = lfsr_step16(s1);
    s3 = lfsr_step16(s2);
    s4 = lfsr_step16(s3);
    psel[0] = resp ? coord_of(s1[14:0]) : pin[0][14:0];
    psel[1] = resp ? coord_of(s2[14:0]) : pin[1][14:0];
    psel[2] = resp ? coord_of(s3[14:0]) : pin[2][14:0];
    // Life is never negative here, so the decrement cannot saturate low
    // beyond what the sign of the 17-bit difference already tells.
    life_dec = (resp ? {2'b0, s4[14:0]} : {1'b0, in_ch.data.life_in}) - LIFE_DEC;
    life_nxt = (life_dec[16] && !life_dec[15]) ? 16'sh8000 : life_dec[15:0];
    tx = cell_of(psel[0], 7'(GRID_X));
    ty = cell_of(psel[1], 7'(GRID_Y));
    tz = cell_of(psel[2], 7'(GRID_Z));
    adv_addr = CELL_AW'((int'(tz) * GRID_Y + int'(ty)) * GRID_X + int'(tx));

    rdv[0] = rd_q[47:32];
    rdv[1] = rd_q[31:16];
    rdv[2] = rd_q[15:0];
    sq     = rdv[k_r] * rdv[k_r];

    vk   = v_r[k_r];
    mag  = vk[15] ? 16'(-vk) : vk;
    prod = 32'(mag) * 32'(ts_r);
    rnd  = {1'b0, prod} + 33'd8192;
    d    = vk[15] ? -20'(rnd[32:14]) : 20'(rnd[32:14]);
    sum  = 21'(signed'({1'b0, p_r[k_r]})) + 21'(d);
    nxt  = (sum > 21'sd32767) ? 16'sh7FFF : (sum < -21'sd32768) ? 16'sh8000 : sum[15:0];
  end

  always_ff @(posedge clk) begin
    if (acc && in_ch.data.func == FUNC_LOAD && load_ok) begin
      grid_mem[load_addr] <= {in_ch.data.vel_x, in_ch.data.vel_y, in_ch.data.vel_z};
    end
    rd_q <= grid_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r <= TS_RESET;
      en_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_STEP: ts_r <= cfg_data;
        REG_ENABLE:    en_r <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lfsr_r      <= LFSR_SEED;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready && !(state_r == S_DONE && out_free)) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (acc && in_ch.data.func == FUNC_ADVANCE && en_r) begin
            for (int i = 0; i < 3; i++) p_r[i] <= psel[i];
            life_r  <= life_nxt;
            resp_r  <= resp;
            addr_r  <= adv_addr;
            if (resp) lfsr_r <= s4;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          s_r     <= '0;
          k_r     <= 2'd0;
          state_r <= S_SQ;
        end
        S_SQ: begin
          s_r <= s_r + 32'(sq);
          k_r <= k_r + 2'd1;
          if (k_r == 2'd2) state_r <= S_CHK;
        end
        S_CHK: begin
          for (int i = 0; i < 3; i++) v_r[i] <= rdv[i];
          k_r     <= 2'd0;
          state_r <= (s_r > NORM_THRESH) ? S_NORM : S_MOVE;
        end
        S_NORM: begin
          if (nrsp.done) begin
            v_r[0]  <= nrsp.vx;
            v_r[1]  <= nrsp.vy;
            v_r[2]  <= nrsp.vz;
            state_r <= S_MOVE;
          end
        end
        S_MOVE: begin
          nx_r[k_r] <= nxt;
          k_r       <= k_r + 2'd1;
          if (k_r == 2'd2) state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_r.next_x    <= nx_r[0];
            out_r.next_y    <= nx_r[1];
            out_r.next_z    <= nx_r[2];
            out_r.prev_x    <= p_r[0];
            out_r.prev_y    <= p_r[1];
            out_r.prev_z    <= p_r[2];
            out_r.life_out  <= life_r;
            out_r.respawned <= resp_r;
            state_r         <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign nreq.start = (state_r == S_CHK) && (s_r > NORM_THRESH);
  assign nreq.sum   = s_r;
  assign nreq.vx    = rdv[0];
  assign nreq.vy    = rdv[1];
  assign nreq.vz    = rdv[2];

  pae_normalize u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (nreq),
    .rsp   (nrsp)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

`ifndef SYNTH
  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n) lfsr_r != 32'h0)
    else $error("random state became zero");
  a_norm_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    nrsp.done |-> state_r == S_NORM)
    else $error("normalize finished outside its wait state");
  a_prev_in_cube: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.prev_x <= ONE_Q14 && out_r.prev_y <= ONE_Q14
                     && out_r.prev_z <= ONE_Q14))
    else $error("prior position outside unit cube");
  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.data.func == FUNC_LOAD) |=> state_r == S_IDLE)
    else $error("load beat started the advance sequencer");
`endif

endmodule

`default_nettype wire

### design/pae_normalize.sv
// ----------------------------------------------------------------------------
// pae_normalize: iterative velocity normalization
// One compare/subtract unit first takes the integer square root of the
// squared length, then divides each component by it, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pae_normalize import pae_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire norm_req_t req,
  output norm_rsp_t      rsp
);

  typedef enum logic [1:0] {N_IDLE, N_SQRT, N_DIV} nstate_t;

  nstate_t     state_r;
  logic [31:0] rem_r;
  logic [31:0] res_r;
  logic [31:0] bit_r;
  logic [15:0] len_r;
  logic [3:0]  sh_r;
  logic [1:0]  k_r;
  logic [12:0] q_r;
  q16_t        vin_r [3];
  q16_t        vout_r [3];
  logic        done_r;

  logic [31:0] sub_b;
  logic [32:0] diff;
  logic        ge;
  logic [31:0] res_nxt;
  q16_t        vk;
  logic [15:0] mag_k;
  logic [12:0] q_nxt;
  q16_t        qs;
  q16_t        vnext;
  logic [15:0] mag_next;

  always_comb begin
    sub_b    = (state_r == N_SQRT) ? (res_r + bit_r) : ({16'b0, len_r} << sh_r);
    diff     = {1'b0, rem_r} - {1'b0, sub_b};
    ge       = !diff[32];
    res_nxt  = ge ? ((res_r >> 1) + bit_r) : (res_r >> 1);
    vk       = vin_r[k_r];
    mag_k    = vk[15] ? 16'(-vk) : vk;
    q_nxt    = q_r | (ge ? (13'd1 << sh_r) : 13'd0);
    qs       = vk[15] ? -q16_t'({3'b0, q_nxt}) : q16_t'({3'b0, q_nxt});
    vnext    = vin_r[(k_r == 2'd2) ? 2'd0 : k_r + 2'd1];
    mag_next = vnext[15] ? 16'(-vnext) : vnext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == N_DIV) && (sh_r == 4'd0) && (k_r == 2'd2);
      case (state_r)
        N_IDLE: begin
          if (req.start) begin
            vin_r[0] <= req.vx;
            vin_r[1] <= req.vy;
            vin_r[2] <= req.vz;
            rem_r    <= req.sum;
            res_r    <= '0;
            bit_r    <= 32'h4000_0000;
            k_r      <= 2'd0;
            state_r  <= N_SQRT;
          end
        end
        N_SQRT: begin
          res_r <= res_nxt;
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            len_r   <= res_nxt[15:0];
            k_r     <= 2'd0;
            sh_r    <= 4'd12;
            q_r     <= '0;
            rem_r   <= {4'b0, mag_k, 12'b0};
            state_r <= N_DIV;
          end else if (ge) begin
            rem_r <= diff[31:0];
          end
        end
        N_DIV: begin
          if (sh_r == 4'd0) begin
            vout_r[k_r] <= qs;
            q_r         <= '0;
            sh_r        <= 4'd12;
            rem_r       <= {4'b0, mag_next, 12'b0};
            k_r         <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
            if (k_r == 2'd2) begin
              state_r <= N_IDLE;
            end
          end else begin
            if (ge) rem_r <= diff[31:0];
            q_r  <= q_nxt;
            sh_r <= sh_r - 4'd1;
          end
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.vx   = vout_r[0];
  assign rsp.vy   = vout_r[1];
  assign rsp.vz   = vout_r[2];

endmodule

`default_nettype wire
